// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hw/rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Constants, types and round functions shared by the hash modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sha256_pkg;
  localparam int unsigned BlockWords = 16;

  typedef logic [31:0] word_t;

  // One entry of the queue between the front and the back: a fully assembled
  // block, with a flag marking the last block of a message.
  typedef struct packed {
    logic [BlockWords*32-1:0] block;
    logic                     final_blk;
  } blk_t;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    k = 32'h0;
    unique case (idx)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage

// File: hw/rtl/sha256_stream_hash.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hash
// Hashes a byte stream and returns the digest as four 64-bit parts.
// ----------------------------------------------------------------------------
// Channel | Handshake   | Payload
// input   | push / full | data_word, byte_count, last_item
// result  | empty / pop | digest_part, part_index, last_part
//
// An item that does not complete a block is taken without holding the input off.
// An item that completes a block holds the input off while the block enters
// a two-entry queue, and longer while that queue is full.
// The round unit takes a block while idle and then runs 64 rounds on it, one a
// cycle.
// A last item adds one or two blocks, then four digest parts; input stays held
// off until the fourth part has been popped.
// Reset returns the hash state to the initial values at once.
`timescale 1ns / 1ps
module sha256_stream_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_item_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] digest_part_o,
  output logic [1:0]  part_index_o,
  output logic        last_part_o
);
  logic             blk_valid, blk_ready, f_full, busy_q;
  logic             core_ready, q_push, q_pop;
  logic [1:0]       q_cnt_q;
  sha256_pkg::blk_t blk, head_q, tail_q;

  // Hold input off from a last item until its digest has been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (push && !full && last_item_i) begin
      busy_q <= 1'b1;
    end else if (pop && !empty && last_part_o) begin
      busy_q <= 1'b0;
    end
  end
  assign full = f_full || busy_q;

  sha256_front u_front (
    .clk_i, .rst_ni,
    .push_i      (push && !busy_q),
    .full_o      (f_full),
    .data_word_i, .byte_count_i, .last_item_i,
    .blk_valid_o (blk_valid),
    .blk_ready_i (blk_ready),
    .blk_o       (blk)
  );

  // Two-entry block queue between the front end and the round unit.
  assign blk_ready = (q_cnt_q != 2'd2);
  assign q_push    = blk_valid && blk_ready;
  assign q_pop     = (q_cnt_q != 2'd0) && core_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt_q <= '0;
    end else begin
      q_cnt_q <= q_cnt_q + {1'b0, q_push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop) begin
      if (q_cnt_q == 2'd2) begin
        head_q <= tail_q;
      end else if (q_push) begin
        head_q <= blk;
      end
    end else if (q_push) begin
      if (q_cnt_q == 2'd0) begin
        head_q <= blk;
      end else begin
        tail_q <= blk;
      end
    end
  end

  sha256_core u_core (
    .clk_i, .rst_ni,
    .blk_valid_i (q_cnt_q != 2'd0),
    .blk_ready_o (core_ready),
    .blk_i       (head_q),
    .empty_o     (empty),
    .pop_i       (pop),
    .digest_part_o, .part_index_o, .last_part_o
  );
endmodule

// File: hw/rtl/sha256_front.sv
// ----------------------------------------------------------------------------
// SHA-256 front end
// Packs message bytes into blocks, pads the last block and counts the length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sha256_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [31:0]         data_word_i,
  input  logic [2:0]          byte_count_i,
  input  logic                last_item_i,
  output logic                blk_valid_o,
  input  logic                blk_ready_i,
  output sha256_pkg::blk_t    blk_o
);
  localparam logic StIdle = 1'b0;
  localparam logic StEmit = 1'b1;

  logic         state_q, state_d;
  logic [511:0] buf_q, buf_d;
  logic [31:0]  carry_q, carry_d;
  logic [5:0]   fill_q, fill_d;
  logic [60:0]  len_q, len_d;
  logic         fin_q, fin_d;
  logic         wrap_q, wrap_d;
  logic         endm_q, endm_d;
  logic [2:0]   cnt;
  logic [6:0]   pos;
  logic [1:0]   lead;

  // Places the 0x80 marker at byte position at and clears every later byte.
  function automatic logic [511:0] pad_block(input logic [511:0] blk, input logic [5:0] at);
    logic [511:0] r;
    r = blk;
    for (int b = 0; b < 64; b++) begin
      if (6'(b) == at) begin
        r[511-8*b -: 8] = 8'h80;
      end else if (6'(b) > at) begin
        r[511-8*b -: 8] = 8'h00;
      end
    end
    return r;
  endfunction

  assign full_o      = (state_q != StIdle);
  assign blk_valid_o = (state_q == StEmit);

  always_comb begin
    blk_o.block     = buf_q;
    blk_o.final_blk = fin_q;
    if (fin_q) begin
      blk_o.block[63:0] = {len_q, 3'b000};
    end
  end

  always_comb begin
    state_d = state_q;
    buf_d   = buf_q;
    carry_d = carry_q;
    fill_d  = fill_q;
    len_d   = len_q;
    fin_d   = fin_q;
    wrap_d  = wrap_q;
    endm_d  = endm_q;
    cnt     = (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
    pos     = {1'b0, fill_q} + {4'd0, cnt};
    lead    = 2'(3'd4 - {1'b0, fill_q[1:0]});
    unique case (state_q)
      StIdle: begin
        if (push_i) begin
          for (int j = 0; j < 4; j++) begin
            if (3'(j) < cnt && {1'b0, fill_q} + 7'(j) < 7'd64) begin
              buf_d[{~(fill_q + 6'(j)), 3'b000} +: 8] = data_word_i[31-8*j -: 8];
            end
          end
          len_d = len_q + 61'(cnt);
          if (pos[6]) begin
            // The bytes that spill past the block wait until it has been handed on.
            carry_d = data_word_i << {lead, 3'b000};
            fill_d  = pos[5:0];
            wrap_d  = 1'b1;
            endm_d  = last_item_i;
            fin_d   = 1'b0;
            state_d = StEmit;
          end else if (last_item_i) begin
            buf_d   = pad_block(buf_d, pos[5:0]);
            fin_d   = (pos < 7'd56);
            endm_d  = (pos >= 7'd56);
            wrap_d  = 1'b0;
            state_d = StEmit;
          end else begin
            fill_d = pos[5:0];
          end
        end
      end
      StEmit: begin
        if (blk_ready_i) begin
          if (fin_q) begin
            state_d = StIdle;
            fill_d  = '0;
            len_d   = '0;
            fin_d   = 1'b0;
            wrap_d  = 1'b0;
            endm_d  = 1'b0;
          end else if (wrap_q) begin
            buf_d[511 -: 32] = carry_q;
            wrap_d           = 1'b0;
            if (endm_q) begin
              buf_d  = pad_block(buf_d, fill_q);
              fin_d  = 1'b1;
              endm_d = 1'b0;
            end else begin
              state_d = StIdle;
            end
          end else if (endm_q) begin
            buf_d  = '0;
            fin_d  = 1'b1;
            endm_d = 1'b0;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      len_q   <= '0;
      fin_q   <= 1'b0;
      wrap_q  <= 1'b0;
      endm_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
      fin_q   <= fin_d;
      wrap_q  <= wrap_d;
      endm_q  <= endm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q   <= buf_d;
    carry_q <= carry_d;
  end
endmodule

// File: hw/rtl/sha256_core.sv
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Runs 64 rounds on a queued block, one round a cycle, and emits the digest after the final block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sha256_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                blk_valid_i,
  output logic                blk_ready_o,
  input  sha256_pkg::blk_t    blk_i,
  output logic                empty_o,
  input  logic                pop_i,
  output logic [63:0]         digest_part_o,
  output logic [1:0]          part_index_o,
  output logic                last_part_o
);
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRound = 2'd1;
  localparam logic [1:0] StOut   = 2'd2;

  logic [1:0]   state_q, state_d;
  logic [31:0]  h_q [8];
  logic [31:0]  v_q [8];
  logic [31:0]  w_q [16];
  logic [5:0]   rnd_q;
  logic         fin_q;
  logic [1:0]   part_q;
  logic [31:0]  t1, t2, s0, s1, wn, wcur, a, e;

  assign blk_ready_o   = (state_q == StIdle);
  assign empty_o       = (state_q != StOut);
  assign digest_part_o = {h_q[{part_q, 1'b0}], h_q[{part_q, 1'b1}]};
  assign part_index_o  = part_q;
  assign last_part_o   = (part_q == 2'd3);

  always_comb begin
    a    = v_q[0];
    e    = v_q[4];
    wcur = w_q[0];
    s0   = sha256_pkg::rotr(w_q[1], 7) ^ sha256_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1   = sha256_pkg::rotr(w_q[14], 17) ^ sha256_pkg::rotr(w_q[14], 19)
         ^ (w_q[14] >> 10);
    wn   = s1 + w_q[9] + s0 + w_q[0];
    t1   = v_q[7] + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11)
         ^ sha256_pkg::rotr(e, 25)) + ((e & v_q[5]) ^ (~e & v_q[6]))
         + sha256_pkg::round_k(rnd_q) + wcur;
    t2   = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13) ^ sha256_pkg::rotr(a, 22))
         + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (blk_valid_i) state_d = StRound;
      StRound: if (rnd_q == 6'd63) state_d = fin_q ? StOut : StIdle;
      StOut:   if (pop_i && part_q == 2'd3) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rnd_q   <= '0;
      part_q  <= '0;
      fin_q   <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::InitHash[255-32*i -: 32];
    end else begin
      state_q <= state_d;
      unique case (state_q)
        StIdle: begin
          rnd_q <= '0;
          part_q <= '0;
          if (blk_valid_i) fin_q <= blk_i.final_blk;
        end
        StRound: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            h_q[0] <= h_q[0] + t1 + t2;
            h_q[4] <= h_q[4] + v_q[3] + t1;
            for (int i = 1; i < 8; i++) begin
              if (i != 4) h_q[i] <= h_q[i] + v_q[i-1];
            end
          end
        end
        StOut: begin
          if (pop_i) begin
            part_q <= part_q + 2'd1;
            if (part_q == 2'd3) begin
              for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::InitHash[255-32*i -: 32];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      for (int i = 0; i < 16; i++) w_q[i] <= blk_i.block[511-32*i -: 32];
    end else if (state_q == StRound) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
    end
  end
endmodule

// File: hw/rtl/sha256_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Watches the ports of the stream hash for ordering of digest parts and for input held off during the digest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha256_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  part_index_o,
  input logic        last_part_o
);
  `ASSERT_IMP(last_flag_a, clk_i, rst_ni, !empty, last_part_o == (part_index_o == 2'd3), "last flag mismatch")
  `ASSERT_NEXT(part_adv_a, clk_i, rst_ni, pop && !empty && !last_part_o, !empty && part_index_o == $past(part_index_o) + 2'd1, "part order broken")
  `ASSERT_IMP(full_out_a, clk_i, rst_ni, !empty, full, "input open during digest")
  `ASSERT_NEXT(hold_a, clk_i, rst_ni, !empty && !pop, !empty && $stable(part_index_o), "part dropped")
endmodule

bind sha256_stream_hash sha256_checker u_checker (.*);
